### sv/htl_pkg.sv
// Shared types and constants for the hash tree table lookup block.
`timescale 1ns / 1ps

package htl_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned VALUE_BITS_DEF  = 16;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_MISSING = 2'd1,
    ST_LOOP    = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  slot;
    logic [63:0] key_hash;
    logic [15:0] entry_value;
    logic [7:0]  entry_lower;
    logic [7:0]  entry_higher;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] match_value;
  } out_item_t;

endpackage

### sv/htl_node_mem.sv
// Node record store: key, value and child links, one write and one registered read port.
`timescale 1ns / 1ps

module htl_node_mem #(
  parameter int unsigned TABLE_DEPTH = htl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = htl_pkg::VALUE_BITS_DEF,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [63:0]           wr_key_i,
  input  logic [VALUE_BITS-1:0] wr_value_i,
  input  logic [7:0]            wr_lower_i,
  input  logic [7:0]            wr_higher_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output logic [63:0]           rd_key_o,
  output logic [VALUE_BITS-1:0] rd_value_o,
  output logic [7:0]            rd_lower_o,
  output logic [7:0]            rd_higher_o
);

  logic [63:0]           key_mem    [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] value_mem  [TABLE_DEPTH];
  logic [7:0]            lower_mem  [TABLE_DEPTH];
  logic [7:0]            higher_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i]    <= wr_key_i;
      value_mem[wr_addr_i]  <= wr_value_i;
      lower_mem[wr_addr_i]  <= wr_lower_i;
      higher_mem[wr_addr_i] <= wr_higher_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o    <= key_mem[rd_addr_i];
      rd_value_o  <= value_mem[rd_addr_i];
      rd_lower_o  <= lower_mem[rd_addr_i];
      rd_higher_o <= higher_mem[rd_addr_i];
    end
  end

endmodule

### sv/hash_tree_table_lookup.sv
// Top level: binary search tree lookup over a table of key hash records.
//
// Usage:
//   Present an item on in_i and raise start; it is taken at a rising edge
//   where start is high and busy is low.
//   A write item (func 0) loads one record into its slot in that cycle and
//   gives no result; a slot at or beyond the table depth is dropped.
//   A lookup item (func 1) walks the tree from root slot 0, one node read
//   from the record memory per cycle; busy stays high through the walk,
//   and the result shows on res_o with done_o high, from a register, once
//   the walk ends. The registered read of the record memory sets the pace:
//   one tree level per cycle; a walk that has read TABLE_DEPTH nodes with
//   no match and no end of links gives a loop status.
//   A new item may start in the cycle that shows a result.
//   done_o is high for exactly one cycle and res_o keeps the result until the next; the receiver cannot stall it.
//   Reset clears the control state only; the table is undefined until
//   loaded and takes no clearing pass.
`timescale 1ns / 1ps

module hash_tree_table_lookup #(
  parameter int unsigned TABLE_DEPTH = htl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = htl_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  htl_pkg::in_item_t  in_i,
  output logic               done_o,
  output htl_pkg::out_item_t res_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  htl_pkg::state_e    state_q, state_d;
  logic [CW-1:0]      reads_q, reads_d;
  logic [63:0]        hash_q, hash_d;
  logic               done_q, done_d;
  htl_pkg::out_item_t res_q, res_d;

  logic                  accept;
  logic                  wr_en;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [63:0]           rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic [7:0]            rd_lower;
  logic [7:0]            rd_higher;
  logic [7:0]            next_link;
  logic                  slot_ok;
  logic                  link_end;

  assign accept  = start && (state_q == htl_pkg::S_IDLE);
  assign slot_ok = (32'(in_i.slot) < 32'(TABLE_DEPTH));
  assign wr_en   = accept && (in_i.func == htl_pkg::FUNC_WRITE) && slot_ok;

  htl_node_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_node_mem (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (AW'(in_i.slot)),
    .wr_key_i    (in_i.key_hash),
    .wr_value_i  (VALUE_BITS'(in_i.entry_value)),
    .wr_lower_i  (in_i.entry_lower),
    .wr_higher_i (in_i.entry_higher),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_key_o    (rd_key),
    .rd_value_o  (rd_value),
    .rd_lower_o  (rd_lower),
    .rd_higher_o (rd_higher)
  );

  assign next_link = (rd_key > hash_q) ? rd_lower : rd_higher;
  assign link_end  = (next_link == 8'd0) || (32'(next_link) >= 32'(TABLE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htl_pkg::S_IDLE;
      reads_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      reads_q <= reads_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d = state_q;
    reads_d = reads_q;
    hash_d  = hash_q;
    done_d  = 1'b0;
    res_d   = res_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      htl_pkg::S_IDLE: begin
        if (accept && (in_i.func == htl_pkg::FUNC_LOOKUP)) begin
          hash_d  = in_i.key_hash;
          rd_en   = 1'b1;
          reads_d = CW'(1);
          state_d = htl_pkg::S_WALK;
        end
      end
      htl_pkg::S_WALK: begin
        if (rd_key == hash_q) begin
          res_d.status      = htl_pkg::ST_FOUND;
          res_d.match_value = 16'(rd_value);
          done_d            = 1'b1;
          state_d           = htl_pkg::S_IDLE;
        end else if (link_end) begin
          res_d.status      = htl_pkg::ST_MISSING;
          res_d.match_value = '0;
          done_d            = 1'b1;
          state_d           = htl_pkg::S_IDLE;
        end else if (reads_q == CW'(TABLE_DEPTH)) begin
          res_d.status      = htl_pkg::ST_LOOP;
          res_d.match_value = '0;
          done_d            = 1'b1;
          state_d           = htl_pkg::S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(next_link);
          reads_d = reads_q + CW'(1);
        end
      end
      default: begin
        state_d = htl_pkg::S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != htl_pkg::S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef ASSERT_OFF
  a_done_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == htl_pkg::S_WALK))
    else $error("result strobe without a walk");

  a_busy_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (in_i.func == htl_pkg::FUNC_LOOKUP)))
    else $error("walk started without an accepted lookup");

  a_reads_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == htl_pkg::S_WALK) |-> (reads_q != '0) && (reads_q <= CW'(TABLE_DEPTH)))
    else $error("read count out of range during walk");

  a_miss_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != htl_pkg::ST_FOUND)) |-> (res_o.match_value == '0))
    else $error("nonzero value on a miss or loop result");
`endif

endmodule

### bench/testbench.sv
// Self-checking bench for hash_tree_table_lookup: tree loads, lookups and a scoreboard.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DEPTH       = htl_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start_r = 1'b0;
  htl_pkg::in_item_t  in_r    = '0;
  logic               busy_w;
  logic               done_w;
  htl_pkg::out_item_t res_w;

  hash_tree_table_lookup u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start_r),
    .busy   (busy_w),
    .in_i   (in_r),
    .done_o (done_w),
    .res_o  (res_w)
  );

  class lookup_scoreboard;
    logic [63:0]        key_mem    [DEPTH];
    logic [15:0]        value_mem  [DEPTH];
    logic [7:0]         lower_mem  [DEPTH];
    logic [7:0]         higher_mem [DEPTH];
    bit                 loaded     [DEPTH];
    htl_pkg::out_item_t lookups_due [$];
    int unsigned        mismatches;

    function new();
      foreach (loaded[i]) begin
        key_mem[i]    = '0;
        value_mem[i]  = '0;
        lower_mem[i]  = '0;
        higher_mem[i] = '0;
        loaded[i]     = 1'b0;
      end
      mismatches = 0;
    endfunction

    // Walk from the root; flag a walk that reads a slot never loaded.
    function bit walk_tree(input logic [63:0] hash, output htl_pkg::out_item_t res);
      int unsigned pos;
      int unsigned reads;
      logic [7:0]  hop;
      bit          touched_blank;
      res.status      = htl_pkg::ST_LOOP;
      res.match_value = '0;
      pos             = 0;
      touched_blank   = 1'b0;
      for (reads = 0; reads < DEPTH; reads++) begin
        if (!loaded[pos]) touched_blank = 1'b1;
        if (key_mem[pos] == hash) begin
          res.status      = htl_pkg::ST_FOUND;
          res.match_value = value_mem[pos];
          break;
        end
        hop = (key_mem[pos] > hash) ? lower_mem[pos] : higher_mem[pos];
        if (hop == 8'd0 || int'(hop) >= DEPTH) begin
          res.status = htl_pkg::ST_MISSING;
          break;
        end
        pos = hop;
      end
      return touched_blank;
    endfunction

    function void note_item(htl_pkg::in_item_t it);
      htl_pkg::out_item_t res;
      if (it.func == htl_pkg::FUNC_WRITE) begin
        if (int'(it.slot) < DEPTH) begin
          key_mem[it.slot]    = it.key_hash;
          value_mem[it.slot]  = it.entry_value
                                & 16'((33'd1 << htl_pkg::VALUE_BITS_DEF) - 1);
          lower_mem[it.slot]  = it.entry_lower;
          higher_mem[it.slot] = it.entry_higher;
          loaded[it.slot]     = 1'b1;
        end
      end else begin
        void'(walk_tree(it.key_hash, res));
        lookups_due.push_back(res);
      end
    endfunction

    function void check_result(htl_pkg::out_item_t got);
      htl_pkg::out_item_t want;
      bit                 bad;
      if (lookups_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d value %h", got.status, got.match_value);
        return;
      end
      want = lookups_due.pop_front();
      bad  = 1'b0;
      if (got.status !== want.status) bad = 1'b1;
      if (got.match_value !== want.match_value) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                   want.status, got.status, want.match_value, got.match_value);
      end
    endfunction
  endclass

  lookup_scoreboard sb;
  int unsigned      items_sent  = 0;
  int unsigned      cycle_count = 0;
  bit               no_idle     = 1'b0;
  logic [63:0]      tree_keys [$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[hash_tree_table_lookup] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_w === 1'b1) sb.check_result(res_w);
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_item(htl_pkg::in_item_t it);
    int unsigned gap;
    in_r    <= it;
    start_r <= 1'b1;
    do @(posedge clk_i); while (busy_w !== 1'b0);
    sb.note_item(it);
    items_sent++;
    gap = gap_len();
    if (gap != 0) begin
      start_r <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_rec(logic [7:0] slot, logic [63:0] key, logic [15:0] val,
                           logic [7:0] lo, logic [7:0] hi);
    htl_pkg::in_item_t it;
    it.func         = htl_pkg::FUNC_WRITE;
    it.slot         = slot;
    it.key_hash     = key;
    it.entry_value  = val;
    it.entry_lower  = lo;
    it.entry_higher = hi;
    send_item(it);
  endtask

  task automatic lookup_key(logic [63:0] key);
    htl_pkg::in_item_t it;
    it.func         = htl_pkg::FUNC_LOOKUP;
    it.slot         = 8'($urandom);
    it.key_hash     = key;
    it.entry_value  = 16'($urandom);
    it.entry_lower  = 8'($urandom);
    it.entry_higher = 8'($urandom);
    send_item(it);
  endtask

  // Hold the sender until every lookup has answered.
  task automatic drain();
    start_r <= 1'b0;
    do @(posedge clk_i); while (sb.lookups_due.size() != 0);
  endtask

  function automatic logic [7:0] any_loaded_slot();
    int unsigned s;
    do s = $urandom_range(0, DEPTH - 1); while (!sb.loaded[s]);
    return 8'(s);
  endfunction

  task automatic load_tree(int unsigned n);
    logic [63:0] tk [DEPTH];
    logic [15:0] tv [DEPTH];
    logic [7:0]  tl [DEPTH];
    logic [7:0]  th [DEPTH];
    int unsigned pool [$];
    int unsigned order [$];
    int unsigned i, j, tmp, pos, s;
    bit          placed;
    logic [63:0] k;
    for (i = 1; i < DEPTH; i++) pool.push_back(i);
    for (i = DEPTH - 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = pool[i]; pool[i] = pool[j]; pool[j] = tmp;
    end
    tree_keys.delete();
    for (i = 0; i < n; i++) begin
      s     = (i == 0) ? 0 : pool[i - 1];
      k     = {$urandom, $urandom};
      tk[s] = k;
      tv[s] = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
      tl[s] = 8'd0;
      th[s] = 8'd0;
      if (i != 0) begin
        pos    = 0;
        placed = 1'b0;
        while (!placed) begin
          if (k < tk[pos]) begin
            if (tl[pos] == 8'd0) begin
              tl[pos] = 8'(s);
              placed  = 1'b1;
            end else pos = tl[pos];
          end else begin
            if (th[pos] == 8'd0) begin
              th[pos] = 8'(s);
              placed  = 1'b1;
            end else pos = th[pos];
          end
        end
      end
      tree_keys.push_back(k);
      order.push_back(s);
    end
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    foreach (order[x]) begin
      s = order[x];
      write_rec(8'(s), tk[s], tv[s], tl[s], th[s]);
    end
  endtask

  task automatic lookup_phase(int unsigned m);
    int unsigned        i, r;
    logic [63:0]        key;
    logic [7:0]         lo, hi;
    htl_pkg::out_item_t scratch;
    for (i = 0; i < m; i++) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        if (r < 62) key = tree_keys[$urandom_range(0, tree_keys.size() - 1)];
        else if (r < 78) key = {$urandom, $urandom};
        else begin
          key = tree_keys[$urandom_range(0, tree_keys.size() - 1)];
          key = $urandom_range(0, 1) ? key + 64'd1 : key - 64'd1;
        end
        if (sb.walk_tree(key, scratch)) key = sb.key_mem[0];
        lookup_key(key);
      end else begin
        lo = ($urandom_range(0, 2) == 0) ? 8'd0 : any_loaded_slot();
        hi = ($urandom_range(0, 2) == 0) ? 8'd0 : any_loaded_slot();
        write_rec(8'($urandom), {$urandom, $urandom}, 16'($urandom), lo, hi);
      end
    end
  endtask

  initial begin
    int unsigned r, n;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_rec(8'd255, '1, 16'h0000, 8'd0, 8'd0);
    write_rec(8'd1, '0, 16'h0001, 8'd0, 8'd0);
    write_rec(8'd0, 64'h8000_0000_0000_0000, 16'hFFFF, 8'd1, 8'd255);
    lookup_key(64'h8000_0000_0000_0000);
    lookup_key('0);
    lookup_key('1);
    lookup_key(64'd1);
    lookup_key(64'hFFFF_FFFF_FFFF_FFFE);
    lookup_key(64'h7FFF_FFFF_FFFF_FFFF);
    write_rec(8'd128, 64'd5, 16'h5555, 8'd128, 8'd128);
    write_rec(8'd1, '0, 16'h0001, 8'd0, 8'd128);
    lookup_key(64'd5);
    lookup_key(64'd7);
    lookup_key(64'd3);
    drain();

    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 16);
      else if (r < 95) n = $urandom_range(17, 80);
      else n = $urandom_range(200, DEPTH);
      load_tree(n);
      lookup_phase($urandom_range(10, 40));
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.lookups_due.size() == 0) begin
      $display("[hash_tree_table_lookup] OK");
    end else begin
      $display("[hash_tree_table_lookup] ERROR");
    end
    $finish;
  end

endmodule
